// ===== sv/baro_temp_pressure_compensate_defines.svh =====
// Assertion macros for the barometric compensation block.
// Taken in by the RTL files that carry concurrent checks; no other dependency.
`ifndef BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH
`define BARO_TEMP_PRESSURE_COMPENSATE_DEFINES_SVH

`ifndef SYNTHESIS

// Plain property, sampled on the rising edge, off during reset
`define BTPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("btpc: assertion failed");

// Antecedent now, consequent in the next cycle
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("btpc: next-cycle assertion failed");

`else

`define BTPC_ASSERT(lbl, clk, rst_n, prop)
`define BTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/btpc_pkg.sv =====
// Shared types and constants for the barometric compensation block.
// No dependencies; used by the interfaces, the register file and the top level.
package btpc_pkg;

  // Field widths
  localparam int RAW_W     = 24;
  localparam int COEFF_W   = 16;
  localparam int OUT_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Internal datapath widths, sized to the value ranges
  localparam int DT_W   = RAW_W + 1;
  localparam int MTS_W  = DT_W + COEFF_W + 1;
  localparam int MDD_W  = 2 * DT_W;
  localparam int T2_W   = 18;
  localparam int TEMP_W = 20;
  localparam int OFF_W  = 41;
  localparam int SENS_W = 40;
  localparam int SQ_W   = 2 * TEMP_W;
  localparam int CORR_W = 48;
  localparam int SLO_W  = 20;
  localparam int SHI_W  = SENS_W - SLO_W;
  localparam int PLO_W  = RAW_W + SLO_W;
  localparam int PHI_W  = RAW_W + 1 + SHI_W;
  localparam int PROD_W = 64;
  localparam int Q_W    = 44;
  localparam int SAT_W  = 48;

  // Shift amounts of the compensation formulae
  localparam int TREF_SH      = 8;
  localparam int TS_SH        = 23;
  localparam int TCO_SH       = 7;
  localparam int TCS_SH       = 8;
  localparam int OFF_BASE_SH  = 16;
  localparam int SENS_BASE_SH = 15;
  localparam int T2_SH        = 31;
  localparam int DIV16_SH     = 4;
  localparam int P1_SH        = 21;
  localparam int P2_SH        = 15;

  // Temperature thresholds in 0.01 degC
  localparam logic signed [TEMP_W-1:0] TEMP_BASE   = TEMP_W'(2000);
  localparam logic signed [TEMP_W-1:0] COLD_LIMIT  = -TEMP_W'(1500);
  localparam logic signed [TEMP_W-1:0] COLD_OFFSET = TEMP_W'(1500);

  // Second-order correction factors
  localparam logic signed [CORR_W-1:0] OFF2_LO_K  = CORR_W'(61);
  localparam logic signed [CORR_W-1:0] SENS2_LO_K = CORR_W'(29);
  localparam logic signed [CORR_W-1:0] OFF2_HI_K  = CORR_W'(17);
  localparam logic signed [CORR_W-1:0] SENS2_HI_K = CORR_W'(9);

  // Saturation limits at the output width
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(2**(OUT_W-1) - 1);
  localparam logic signed [SAT_W-1:0] SAT_MIN = -SAT_MAX - SAT_W'(1);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } cfg_idx_e;

  // Calibration words as seen by the datapath
  typedef struct packed {
    logic [COEFF_W-1:0] sens_coeff;
    logic [COEFF_W-1:0] off_coeff;
    logic [COEFF_W-1:0] tcs_coeff;
    logic [COEFF_W-1:0] tco_coeff;
    logic [COEFF_W-1:0] tref_coeff;
    logic [COEFF_W-1:0] tempsens_coeff;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    sens_coeff:     COEFF_W'(40127),
    off_coeff:      COEFF_W'(36924),
    tcs_coeff:      COEFF_W'(23317),
    tco_coeff:      COEFF_W'(23282),
    tref_coeff:     COEFF_W'(33464),
    tempsens_coeff: COEFF_W'(28312)
  };

endpackage

// ===== sv/btpc_if.sv =====
// Valid/ready stream interfaces for raw conversion pairs and compensated results.
// Depends on btpc_pkg for the field widths.
interface btpc_raw_if;
  logic                          valid;
  logic                          ready;
  logic [btpc_pkg::RAW_W-1:0]    raw_pressure;
  logic [btpc_pkg::RAW_W-1:0]    raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface btpc_comp_if;
  logic                                valid;
  logic                                ready;
  logic signed [btpc_pkg::OUT_W-1:0]   temp_centideg;
  logic signed [btpc_pkg::OUT_W-1:0]   pressure_pascal;

  modport source (output valid, output temp_centideg, output pressure_pascal, input ready);
  modport sink   (input valid, input temp_centideg, input pressure_pascal, output ready);
endinterface

// ===== sv/btpc_cfg_regs.sv =====
// Calibration register file: six 16-bit words behind a plain write port.
// Depends on btpc_pkg for the index codes, the word struct and reset values.
module btpc_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [btpc_pkg::COEFF_W-1:0]       cfg_wdata_i,
  output btpc_pkg::cfg_t                     cfg_o
);

  btpc_pkg::cfg_t cfg_q;

  // Decode and store; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= btpc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        btpc_pkg::REG_SENS:     cfg_q.sens_coeff     <= cfg_wdata_i;
        btpc_pkg::REG_OFF:      cfg_q.off_coeff      <= cfg_wdata_i;
        btpc_pkg::REG_TCS:      cfg_q.tcs_coeff      <= cfg_wdata_i;
        btpc_pkg::REG_TCO:      cfg_q.tco_coeff      <= cfg_wdata_i;
        btpc_pkg::REG_TREF:     cfg_q.tref_coeff     <= cfg_wdata_i;
        btpc_pkg::REG_TEMPSENS: cfg_q.tempsens_coeff <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/baro_temp_pressure_compensate.sv =====
// Barometric sensor compensation: eight-stage pipeline with calibration registers.
// Depends on btpc_pkg, btpc_if.sv, btpc_cfg_regs and the assertion macro header.
//
// Usage:
//   raw_i carries one beat per conversion pair (raw_pressure, raw_temperature).
//   comp_o returns one beat per pair: temperature in 0.01 degC and pressure
//   in Pa, both saturated to 32-bit signed, in the order the pairs came in.
//   Calibration words are written through cfg_we_i/cfg_idx_i/cfg_wdata_i,
//   one word per cycle, while no beat is in flight.
// Throughput: one beat per cycle while comp_o is ready. Each stage has its
//   own enable, so a stalled receiver holds only the stages that are full;
//   bubbles in front of the stall still fill, and input is refused only
//   when all eight stages hold a beat. The sensitivity product is split
//   into two 24x20 partial products in stage 6 and summed in stage 7.
// Reset: all stage valid bits clear, comp_o.valid drops, and the calibration
//   words return to their factory defaults.
`include "baro_temp_pressure_compensate_defines.svh"

module baro_temp_pressure_compensate (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [btpc_pkg::COEFF_W-1:0]      cfg_wdata_i,
  btpc_raw_if.sink                          raw_i,
  btpc_comp_if.source                       comp_o
);

  localparam int NSTG = 8;

  localparam int RAW_W  = btpc_pkg::RAW_W;
  localparam int DT_W   = btpc_pkg::DT_W;
  localparam int MTS_W  = btpc_pkg::MTS_W;
  localparam int MDD_W  = btpc_pkg::MDD_W;
  localparam int T2_W   = btpc_pkg::T2_W;
  localparam int TEMP_W = btpc_pkg::TEMP_W;
  localparam int OFF_W  = btpc_pkg::OFF_W;
  localparam int SENS_W = btpc_pkg::SENS_W;
  localparam int SQ_W   = btpc_pkg::SQ_W;
  localparam int CORR_W = btpc_pkg::CORR_W;
  localparam int SLO_W  = btpc_pkg::SLO_W;
  localparam int PLO_W  = btpc_pkg::PLO_W;
  localparam int PHI_W  = btpc_pkg::PHI_W;
  localparam int PROD_W = btpc_pkg::PROD_W;
  localparam int Q_W    = btpc_pkg::Q_W;
  localparam int SAT_W  = btpc_pkg::SAT_W;
  localparam int OUT_W  = btpc_pkg::OUT_W;

  // Clamp a wide signed value to the output range
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > btpc_pkg::SAT_MAX) begin
      r = btpc_pkg::SAT_MAX[OUT_W-1:0];
    end else if (v < btpc_pkg::SAT_MIN) begin
      r = btpc_pkg::SAT_MIN[OUT_W-1:0];
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  btpc_pkg::cfg_t cfg;

  btpc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Stage valid bits and per-stage enables
  logic [NSTG-1:0] v_q, v_d, en;

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || comp_o.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        v_d[k] = (k == 0) ? raw_i.valid : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign raw_i.ready = en[0];

  // Stage 1: temperature difference
  logic signed [DT_W-1:0] s1_dt_q, s1_dt_d;
  logic [RAW_W-1:0]       s1_d1_q;

  assign s1_dt_d = $signed(DT_W'(raw_i.raw_temperature))
                 - $signed(DT_W'(cfg.tref_coeff) << btpc_pkg::TREF_SH);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_dt_q <= s1_dt_d;
      s1_d1_q <= raw_i.raw_pressure;
    end
  end

  // Stage 2: first-order products against dT
  logic signed [MTS_W-1:0] s2_mts_q, s2_mtco_q, s2_mtcs_q;
  logic signed [MTS_W-1:0] s2_mts_d, s2_mtco_d, s2_mtcs_d;
  logic signed [MDD_W-1:0] s2_mdd_q, s2_mdd_d;
  logic [RAW_W-1:0]        s2_d1_q;

  always_comb begin
    s2_mts_d  = s1_dt_q * $signed({1'b0, cfg.tempsens_coeff});
    s2_mtco_d = s1_dt_q * $signed({1'b0, cfg.tco_coeff});
    s2_mtcs_d = s1_dt_q * $signed({1'b0, cfg.tcs_coeff});
    s2_mdd_d  = s1_dt_q * s1_dt_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s2_mts_q  <= s2_mts_d;
      s2_mtco_q <= s2_mtco_d;
      s2_mtcs_q <= s2_mtcs_d;
      s2_mdd_q  <= s2_mdd_d;
      s2_d1_q   <= s1_d1_q;
    end
  end

  // Stage 3: first-order temperature, offset, sensitivity and T2
  logic signed [TEMP_W-1:0] s3_temp_q, s3_temp_d;
  logic signed [OFF_W-1:0]  s3_off_q, s3_off_d;
  logic signed [SENS_W-1:0] s3_sens_q, s3_sens_d;
  logic [T2_W-1:0]          s3_t2_q, s3_t2_d;
  logic [RAW_W-1:0]         s3_d1_q;

  always_comb begin
    s3_temp_d = TEMP_W'(s2_mts_q >>> btpc_pkg::TS_SH) + btpc_pkg::TEMP_BASE;
    s3_off_d  = OFF_W'(s2_mtco_q >>> btpc_pkg::TCO_SH)
              + (OFF_W'(cfg.off_coeff) << btpc_pkg::OFF_BASE_SH);
    s3_sens_d = SENS_W'(s2_mtcs_q >>> btpc_pkg::TCS_SH)
              + (SENS_W'(cfg.sens_coeff) << btpc_pkg::SENS_BASE_SH);
    // dT squared is never negative, so a plain bit slice does the shift
    s3_t2_d   = s2_mdd_q[btpc_pkg::T2_SH + T2_W - 1:btpc_pkg::T2_SH];
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s3_temp_q <= s3_temp_d;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_t2_q   <= s3_t2_d;
      s3_d1_q   <= s2_d1_q;
    end
  end

  // Stage 4: cold flags and the squared temperature distances
  logic signed [TEMP_W-1:0] s4_temp_q;
  logic signed [OFF_W-1:0]  s4_off_q;
  logic signed [SENS_W-1:0] s4_sens_q;
  logic [T2_W-1:0]          s4_t2_q;
  logic [RAW_W-1:0]         s4_d1_q;
  logic                     s4_cold_q, s4_vcold_q, s4_cold_d, s4_vcold_d;
  logic signed [SQ_W-1:0]   s4_sq_q, s4_sq2_q, s4_sq_d, s4_sq2_d;
  logic signed [TEMP_W-1:0] dlo, dvl;

  always_comb begin
    s4_cold_d  = s3_temp_q < btpc_pkg::TEMP_BASE;
    s4_vcold_d = s3_temp_q < btpc_pkg::COLD_LIMIT;
    dlo        = s3_temp_q - btpc_pkg::TEMP_BASE;
    dvl        = s3_temp_q + btpc_pkg::COLD_OFFSET;
    s4_sq_d    = dlo * dlo;
    s4_sq2_d   = dvl * dvl;
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s4_temp_q  <= s3_temp_q;
      s4_off_q   <= s3_off_q;
      s4_sens_q  <= s3_sens_q;
      s4_t2_q    <= s3_t2_q;
      s4_d1_q    <= s3_d1_q;
      s4_cold_q  <= s4_cold_d;
      s4_vcold_q <= s4_vcold_d;
      s4_sq_q    <= s4_sq_d;
      s4_sq2_q   <= s4_sq2_d;
    end
  end

  // Stage 5: second-order correction (squares are non-negative, so /16 is a shift)
  logic signed [CORR_W-1:0] off2, sens2;
  logic signed [TEMP_W-1:0] s5_temp_q, s5_temp_d;
  logic signed [OFF_W-1:0]  s5_off_q, s5_off_d;
  logic signed [SENS_W-1:0] s5_sens_q, s5_sens_d;
  logic [RAW_W-1:0]         s5_d1_q;

  always_comb begin
    off2  = ((CORR_W'(s4_sq_q) * btpc_pkg::OFF2_LO_K) >>> btpc_pkg::DIV16_SH)
          + (s4_vcold_q ? CORR_W'(s4_sq2_q) * btpc_pkg::OFF2_HI_K : '0);
    sens2 = ((CORR_W'(s4_sq_q) * btpc_pkg::SENS2_LO_K) >>> btpc_pkg::DIV16_SH)
          + (s4_vcold_q ? CORR_W'(s4_sq2_q) * btpc_pkg::SENS2_HI_K : '0);
    if (s4_cold_q) begin
      s5_temp_d = s4_temp_q - $signed(TEMP_W'(s4_t2_q));
      s5_off_d  = s4_off_q - OFF_W'(off2);
      s5_sens_d = s4_sens_q - SENS_W'(sens2);
    end else begin
      s5_temp_d = s4_temp_q;
      s5_off_d  = s4_off_q;
      s5_sens_d = s4_sens_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s5_temp_q <= s5_temp_d;
      s5_off_q  <= s5_off_d;
      s5_sens_q <= s5_sens_d;
      s5_d1_q   <= s4_d1_q;
    end
  end

  // Stage 6: D1 * SENS as two partial products
  logic [PLO_W-1:0]         s6_plo_q, s6_plo_d;
  logic signed [PHI_W-1:0]  s6_phi_q, s6_phi_d;
  logic signed [TEMP_W-1:0] s6_temp_q;
  logic signed [OFF_W-1:0]  s6_off_q;

  always_comb begin
    s6_plo_d = s5_d1_q * s5_sens_q[SLO_W-1:0];
    s6_phi_d = $signed({1'b0, s5_d1_q}) * $signed(s5_sens_q[SENS_W-1:SLO_W]);
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s6_plo_q  <= s6_plo_d;
      s6_phi_q  <= s6_phi_d;
      s6_temp_q <= s5_temp_q;
      s6_off_q  <= s5_off_q;
    end
  end

  // Stage 7: sum the partial products and scale
  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    s7_scaled_q, s7_scaled_d;
  logic signed [TEMP_W-1:0] s7_temp_q;
  logic signed [OFF_W-1:0]  s7_off_q;

  always_comb begin
    prod        = (PROD_W'(s6_phi_q) <<< SLO_W) + PROD_W'(s6_plo_q);
    s7_scaled_d = Q_W'(prod >>> btpc_pkg::P1_SH);
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s7_scaled_q <= s7_scaled_d;
      s7_temp_q   <= s6_temp_q;
      s7_off_q    <= s6_off_q;
    end
  end

  // Stage 8: remove offset, final scale, saturate into the output register
  logic signed [Q_W-1:0]   diff, pres;
  logic signed [OUT_W-1:0] s8_temp_q, s8_temp_d, s8_pres_q, s8_pres_d;

  always_comb begin
    diff      = s7_scaled_q - Q_W'(s7_off_q);
    pres      = diff >>> btpc_pkg::P2_SH;
    s8_temp_d = sat_out(SAT_W'(s7_temp_q));
    s8_pres_d = sat_out(SAT_W'(pres));
  end

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      s8_temp_q <= s8_temp_d;
      s8_pres_q <= s8_pres_d;
    end
  end

  assign comp_o.valid           = v_q[NSTG-1];
  assign comp_o.temp_centideg   = s8_temp_q;
  assign comp_o.pressure_pascal = s8_pres_q;

  // Checks on the pipeline control
  `BTPC_ASSERT_NEXT(a_accept_enters, clk_i, rst_ni, raw_i.valid && raw_i.ready, v_q[0])
  `BTPC_ASSERT(a_full_stall_blocks, clk_i, rst_ni, (&v_q && !comp_o.ready) |-> !raw_i.ready)
  `BTPC_ASSERT(a_vcold_implies_cold, clk_i, rst_ni, v_q[3] |-> (!s4_vcold_q || s4_cold_q))
  `BTPC_ASSERT_NEXT(a_stage1_holds, clk_i, rst_ni, v_q[0] && !en[0], v_q[0] && $stable(s1_dt_q))

endmodule

// ===== verif/baro_temp_pressure_compensate_checker.sv =====
// Result checker for the barometric compensation block: tracks the calibration
// words, predicts each result beat and compares it with comp beats in order.
// Depends on btpc_pkg and the stream interfaces of btpc_if.sv.
module baro_compensation_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [btpc_pkg::COEFF_W-1:0]   cfg_wdata_i,
  btpc_raw_if                            raw,
  btpc_comp_if                           comp,
  output int                             fails_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [btpc_pkg::OUT_W-1:0] temp_centideg;
    logic signed [btpc_pkg::OUT_W-1:0] pressure_pascal;
  } comp_beat_t;

  localparam longint S32_MAX = 2147483647;
  localparam longint S32_MIN = -S32_MAX - 1;

  btpc_pkg::cfg_t calib = btpc_pkg::CFG_RESET;
  comp_beat_t     awaited_q[$];
  int             fail_cnt = 0;

  // Clamp a 64-bit value to the signed 32-bit output range
  function automatic logic signed [btpc_pkg::OUT_W-1:0] clip_s32(input longint v);
    if (v > S32_MAX) return btpc_pkg::OUT_W'(S32_MAX);
    if (v < S32_MIN) return btpc_pkg::OUT_W'(S32_MIN);
    return btpc_pkg::OUT_W'(v);
  endfunction

  // Second-order compensation, 64-bit signed wrapping arithmetic throughout
  function automatic comp_beat_t compensate_pair(input btpc_pkg::cfg_t c,
                                                 input logic [btpc_pkg::RAW_W-1:0] rp,
                                                 input logic [btpc_pkg::RAW_W-1:0] rt);
    longint d1, d2, tref, tsens, tco, tcs, offc, sensc;
    longint dt, temp, off, sens, t2, dlo, sq, off2, sens2, dvl, sq2, p;
    comp_beat_t r;
    d1    = rp;
    d2    = rt;
    tref  = c.tref_coeff;
    tsens = c.tempsens_coeff;
    tco   = c.tco_coeff;
    tcs   = c.tcs_coeff;
    offc  = c.off_coeff;
    sensc = c.sens_coeff;

    dt   = d2 - tref * 256;
    temp = 2000 + ((dt * tsens) >>> 23);
    off  = offc * 65536 + ((tco * dt) >>> 7);
    sens = sensc * 32768 + ((tcs * dt) >>> 8);

    // cold correction, with an extra tier below -15 degC
    if (temp < 2000) begin
      t2    = (dt * dt) >>> 31;
      dlo   = temp - 2000;
      sq    = dlo * dlo;
      off2  = (61 * sq) / 16;
      sens2 = (29 * sq) / 16;
      if (temp < -1500) begin
        dvl   = temp + 1500;
        sq2   = dvl * dvl;
        off2  = off2 + 17 * sq2;
        sens2 = sens2 + 9 * sq2;
      end
      temp = temp - t2;
      off  = off - off2;
      sens = sens - sens2;
    end

    p = (((d1 * sens) >>> 21) - off) >>> 15;

    r.temp_centideg   = clip_s32(temp);
    r.pressure_pascal = clip_s32(p);
    return r;
  endfunction

  // Compare result beats, queue predictions, then shadow register writes
  always @(posedge clk_i or negedge rst_ni) begin
    comp_beat_t exp_beat;
    if (!rst_ni) begin
      calib = btpc_pkg::CFG_RESET;
      awaited_q.delete();
    end else begin
      if (comp.valid && comp.ready) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with no prediction waiting: temp %0d, pressure %0d",
                 comp.temp_centideg, comp.pressure_pascal);
          fail_cnt++;
        end else begin
          exp_beat = awaited_q.pop_front();
          if (comp.temp_centideg !== exp_beat.temp_centideg) begin
            $error("temp_centideg: expected %0d, got %0d",
                   exp_beat.temp_centideg, comp.temp_centideg);
            fail_cnt++;
          end
          if (comp.pressure_pascal !== exp_beat.pressure_pascal) begin
            $error("pressure_pascal: expected %0d, got %0d",
                   exp_beat.pressure_pascal, comp.pressure_pascal);
            fail_cnt++;
          end
        end
      end

      if (raw.valid && raw.ready)
        awaited_q.push_back(compensate_pair(calib, raw.raw_pressure,
                                            raw.raw_temperature));

      // spare indexes fall through and are ignored
      if (cfg_we_i) begin
        case (cfg_idx_i)
          btpc_pkg::REG_SENS:     calib.sens_coeff     = cfg_wdata_i;
          btpc_pkg::REG_OFF:      calib.off_coeff      = cfg_wdata_i;
          btpc_pkg::REG_TCS:      calib.tcs_coeff      = cfg_wdata_i;
          btpc_pkg::REG_TCO:      calib.tco_coeff      = cfg_wdata_i;
          btpc_pkg::REG_TREF:     calib.tref_coeff     = cfg_wdata_i;
          btpc_pkg::REG_TEMPSENS: calib.tempsens_coeff = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    fails_o   <= fail_cnt;
    pending_o <= awaited_q.size();
  end

endmodule

// ===== verif/baro_temp_pressure_compensate_tb.sv =====
// Top of the barometric compensation testbench: clock, reset, calibration
// phases, raw beats with random gaps and result back-pressure, and the verdict.
// Depends on btpc_pkg, btpc_if.sv, the block and baro_compensation_checker.
module baro_temp_pressure_compensate_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAW_MAX      = (1 << btpc_pkg::RAW_W) - 1;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam int EDGE_ITEMS   = 4;
  localparam int DIRECTED_N   = 17;
  localparam int TAIL_CYCLES  = 20;

  // Indexes past the last register
  localparam logic [btpc_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [btpc_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  // {raw_pressure, raw_temperature}; reference point of the reset
  // calibration is 8566784, the cold tiers sit just below it
  localparam logic [2*btpc_pkg::RAW_W-1:0] DIRECTED [DIRECTED_N] = '{
    {24'd0,        24'd0},
    {24'hFFFFFF,   24'hFFFFFF},
    {24'd0,        24'hFFFFFF},
    {24'hFFFFFF,   24'd0},
    {24'hFFFFFF,   24'd8566784},
    {24'hFFFFFF,   24'd8566783},
    {24'hFFFFFF,   24'd8566785},
    {24'hAAAAAA,   24'h555555},
    {24'h555555,   24'hAAAAAA},
    {24'hFFFFFF,   24'd8066784},
    {24'hFFFFFF,   24'd7529753},
    {24'hFFFFFF,   24'd7529752},
    {24'hFFFFFF,   24'd7529744},
    {24'hFFFFFF,   24'd6566784},
    {24'h800000,   24'd1000000},
    {24'd1,        24'd1},
    {24'hFFFFFF,   24'd16000000}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we;
  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [btpc_pkg::COEFF_W-1:0]   cfg_wdata;
  int                             fails;
  int                             pending;
  int                             quiet_cycles = 0;
  bit                             no_idle = 1'b0;
  logic [btpc_pkg::COEFF_W-1:0]   cur_tref = btpc_pkg::CFG_RESET.tref_coeff;

  btpc_raw_if  raw_if ();
  btpc_comp_if comp_if ();

  baro_temp_pressure_compensate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .raw_i       (raw_if),
    .comp_o      (comp_if)
  );

  baro_compensation_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .raw         (raw_if),
    .comp        (comp_if),
    .fails_o     (fails),
    .pending_o   (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // One raw beat after a random gap; valid stays up across back-to-back beats
  task automatic send_pair(input logic [btpc_pkg::RAW_W-1:0] p,
                           input logic [btpc_pkg::RAW_W-1:0] t);
    int gap;
    if ($urandom_range(0, 23) == 0) no_idle = !no_idle;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      raw_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    raw_if.valid           <= 1'b1;
    raw_if.raw_pressure    <= p;
    raw_if.raw_temperature <= t;
    do @(posedge clk_i); while (!raw_if.ready);
  endtask

  // Hold off input until every predicted result has come out
  task automatic drain();
    raw_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic write_coeff(input logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [btpc_pkg::COEFF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
  endtask

  // All six words, then the spare indexes, which must not disturb them
  task automatic program_calib(input btpc_pkg::cfg_t c);
    write_coeff(btpc_pkg::REG_SENS,     c.sens_coeff);
    write_coeff(btpc_pkg::REG_OFF,      c.off_coeff);
    write_coeff(btpc_pkg::REG_TCS,      c.tcs_coeff);
    write_coeff(btpc_pkg::REG_TCO,      c.tco_coeff);
    write_coeff(btpc_pkg::REG_TREF,     c.tref_coeff);
    write_coeff(btpc_pkg::REG_TEMPSENS, c.tempsens_coeff);
    write_coeff(IDX_SPARE_LO, btpc_pkg::COEFF_W'($urandom));
    write_coeff(IDX_SPARE_HI, btpc_pkg::COEFF_W'($urandom));
    cfg_we   <= 1'b0;
    cur_tref = c.tref_coeff;
  endtask

  // Result side: random stall before each beat, none while no_idle is set
  initial begin
    int stall;
    comp_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        comp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      comp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!comp_if.valid);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((raw_if.valid && raw_if.ready) || (comp_if.valid && comp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Stimulus
  initial begin
    btpc_pkg::cfg_t                c;
    int                            base;
    int                            span;
    int                            v;
    logic [btpc_pkg::RAW_W-1:0]    rp;
    logic [btpc_pkg::RAW_W-1:0]    rt;

    raw_if.valid           <= 1'b0;
    raw_if.raw_pressure    <= '0;
    raw_if.raw_temperature <= '0;
    cfg_we                 <= 1'b0;
    cfg_idx                <= '0;
    cfg_wdata              <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed extremes and cold tiers at the reset calibration
    for (int i = 0; i < DIRECTED_N; i++)
      send_pair(DIRECTED[i][2*btpc_pkg::RAW_W-1:btpc_pkg::RAW_W],
                DIRECTED[i][btpc_pkg::RAW_W-1:0]);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        c.sens_coeff     = btpc_pkg::COEFF_W'($urandom);
        c.off_coeff      = btpc_pkg::COEFF_W'($urandom);
        c.tcs_coeff      = btpc_pkg::COEFF_W'($urandom);
        c.tco_coeff      = btpc_pkg::COEFF_W'($urandom);
        c.tref_coeff     = btpc_pkg::COEFF_W'($urandom);
        c.tempsens_coeff = btpc_pkg::COEFF_W'($urandom);
        case (ph)
          1: c = '1;
          2: c = '0;
          3: c.tref_coeff = '0;
          4: begin
            c.tref_coeff     = '1;
            c.tempsens_coeff = '1;
          end
          PHASES - 1: c = btpc_pkg::CFG_RESET;
          default: ;
        endcase
        program_calib(c);
      end

      for (int i = 0; i < EDGE_ITEMS; i++)
        send_pair(DIRECTED[i][2*btpc_pkg::RAW_W-1:btpc_pkg::RAW_W],
                  DIRECTED[i][btpc_pkg::RAW_W-1:0]);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        rp = btpc_pkg::RAW_W'($urandom);
        if ($urandom_range(0, 9) < 7) begin
          // temperature around the reference point, at a random scale
          base = int'(cur_tref) * 256;
          span = 1 << $urandom_range(4, 23);
          v    = base + $urandom_range(0, 2 * span) - span;
          if (v < 0) v = 0;
          if (v > RAW_MAX) v = RAW_MAX;
          rt = btpc_pkg::RAW_W'(v);
        end else begin
          rt = btpc_pkg::RAW_W'($urandom);
        end
        send_pair(rp, rt);
        if (ph == 3 && n == PHASE_ITEMS / 2) drain();
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fails == 0 && pending == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
